// ===== design/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg
// types and lookup tables for the hex marching tetrahedra block
// ----------------------------------------------------------------------------
`default_nettype none

package hmt_pkg;

	typedef struct packed {
		logic [63:0] corner_0;
		logic [63:0] corner_1;
		logic [63:0] corner_2;
		logic [63:0] corner_3;
		logic [63:0] corner_4;
		logic [63:0] corner_5;
		logic [63:0] corner_6;
		logic [63:0] corner_7;
	} hex_t;

	typedef struct packed {
		logic signed [15:0] p0_x;
		logic signed [15:0] p0_y;
		logic signed [15:0] p0_z;
		logic signed [15:0] p1_x;
		logic signed [15:0] p1_y;
		logic signed [15:0] p1_z;
		logic signed [15:0] p2_x;
		logic signed [15:0] p2_y;
		logic signed [15:0] p2_z;
		logic [2:0]         tet_number;
		logic               last_of_cell;
	} tri_t;

	localparam logic [3:0] LAST_SLOT = 4'd11;

	// hex corners of each tetrahedron, tet corner 0 in the low bits
	function automatic logic [3:0][2:0] tet_corners(input logic [2:0] t);
		logic [3:0][2:0] r;
		unique case (t)
			3'd0: r = {3'd6, 3'd4, 3'd5, 3'd0};
			3'd1: r = {3'd6, 3'd5, 3'd7, 3'd0};
			3'd2: r = {3'd6, 3'd7, 3'd2, 3'd0};
			3'd3: r = {3'd5, 3'd1, 3'd7, 3'd0};
			3'd4: r = {3'd2, 3'd7, 3'd1, 3'd0};
			3'd5: r = {3'd2, 3'd1, 3'd7, 3'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] tri_count(input logic [3:0] code);
		logic [1:0] r;
		unique case (code)
			4'd0, 4'd15: r = 2'd0;
			4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: r = 2'd2;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// edges of each code, 0-2 then 3-5, each {end a, end b} as tet corners
	function automatic logic [5:0][3:0] tri_edges(input logic [3:0] code);
		logic [5:0][3:0] r;
		unique case (code)
			4'd1, 4'd14: r = 24'h000321;
			4'd2, 4'd13: r = 24'h000674;
			4'd3, 4'd12: r = 24'h267723;
			4'd4, 4'd11: r = 24'h000B98;
			4'd5, 4'd10: r = 24'hB613B1;
			4'd6, 4'd9:  r = 24'hB21B71;
			4'd7, 4'd8:  r = 24'h000DEC;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/hex_marching_tetrahedra.sv =====
// a slot runs through edge, setup, divider, multiply and rounding registers
// throughput: one triangle slot per cycle unless stalled, twelve per cell,
//   set by the slot sequencer walking six tetrahedra by two triangles
// the fraction divider is FRAC_BITS pipelined stages, one quotient bit each
// reset clears the sequencer, valid bits and iso level; data is not reset
// ----------------------------------------------------------------------------
// hex_marching_tetrahedra
// splits a hex cell into six tetrahedra and emits interpolated triangles
// ----------------------------------------------------------------------------
`default_nettype none

module hex_marching_tetrahedra
	import hmt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         hex_valid,
	output logic        hex_stall,
	input  hex_t        hex,
	output logic        triangle_valid,
	input  wire         triangle_stall,
	output tri_t        triangle,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data
);

	localparam int F  = FRAC_BITS;
	localparam int PW = F + 19;

	typedef struct packed {
		logic       valid;
		logic [2:0] tet;
		logic       last;
	} ctl_t;

	typedef struct packed {
		logic [2:0][15:0] pa;
		logic [2:0][15:0] pb;
		logic [15:0]      a;
		logic [15:0]      b;
	} edge_t;

	typedef struct packed {
		logic [2:0][15:0] pa;
		logic [2:0][15:0] pb;
		logic [16:0]      rem;
		logic [15:0]      den;
		logic [F-1:0]     q;
		logic             frc;
		logic             one;
	} vtx_t;

	logic signed [15:0] iso_q;
	logic               busy_q;
	logic [3:0]         slot_q;
	logic [7:0][63:0]   corner_q;
	logic [5:0][3:0]    code_q;
	logic [11:0]        mask_q;
	logic [3:0]         last_q;

	ctl_t               ctl_s1, ctl_s2, ctl_s4, ctl_s5;
	ctl_t               ctl_s3 [F];
	edge_t [2:0]        edg_s1;
	vtx_t  [2:0]        vtx_s2;
	vtx_t  [2:0]        vtx_s3 [F];
	logic [2:0][2:0][PW-1:0] prod_s4;
	logic [2:0][2:0][15:0]   pa_s4;
	logic [2:0][2:0][15:0]   p_s5;

	logic               adv, take;
	logic [7:0][63:0]   cin;
	logic [5:0][3:0]    code_d;
	logic [11:0]        mask_d;
	logic [3:0]         last_d;
	edge_t [2:0]        edg_d;
	vtx_t  [2:0]        vtx_d;

	assign cfg_ready = 1'b1;
	assign adv       = !(ctl_s5.valid && triangle_stall);
	assign hex_stall = busy_q && !(slot_q == LAST_SLOT && adv);
	assign take      = hex_valid && !hex_stall;

	assign cin = {hex.corner_7, hex.corner_6, hex.corner_5, hex.corner_4,
	              hex.corner_3, hex.corner_2, hex.corner_1, hex.corner_0};

	always_comb begin
		logic [7:0]      below;
		logic [3:0][2:0] tc;
		for (int c = 0; c < 8; c++) begin
			below[c] = $signed(cin[c][63:48]) < iso_q;
		end
		last_d = '0;
		for (int t = 0; t < 6; t++) begin
			tc = tet_corners(3'(t));
			for (int i = 0; i < 4; i++) begin
				code_d[t][i] = below[tc[i]];
			end
			mask_d[2*t]   = tri_count(code_d[t]) != 2'd0;
			mask_d[2*t+1] = tri_count(code_d[t]) == 2'd2;
		end
		for (int s = 0; s < 12; s++) begin
			if (mask_d[s]) begin
				last_d = 4'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q  <= '0;
			busy_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				iso_q <= cfg_data;
			end
			if (take) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (busy_q && adv) begin
				if (slot_q == LAST_SLOT) begin
					busy_q <= 1'b0;
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			corner_q <= cin;
			code_q   <= code_d;
			mask_q   <= mask_d;
			last_q   <= last_d;
		end
	end

	// slot to edge ends
	always_comb begin
		logic [2:0]      t;
		logic [3:0]      code;
		logic [5:0][3:0] eds;
		logic [3:0]      e;
		logic [3:0][2:0] tc;
		logic [2:0]      ca, cb, lo, hi;
		t    = slot_q[3:1];
		code = code_q[t];
		eds  = tri_edges(code);
		tc   = tet_corners(t);
		for (int v = 0; v < 3; v++) begin
			e  = eds[slot_q[0] ? 3 + v : v];
			ca = tc[e[3:2]];
			cb = tc[e[1:0]];
			lo = (ca < cb) ? ca : cb;
			hi = (ca < cb) ? cb : ca;
			for (int d = 0; d < 3; d++) begin
				edg_d[v].pa[d] = corner_q[lo][16*d +: 16];
				edg_d[v].pb[d] = corner_q[hi][16*d +: 16];
			end
			edg_d[v].a = corner_q[lo][63:48];
			edg_d[v].b = corner_q[hi][63:48];
		end
	end

	// fraction setup
	always_comb begin
		logic signed [16:0] num, den;
		for (int v = 0; v < 3; v++) begin
			num = 17'(iso_q) - 17'($signed(edg_s1[v].a));
			den = 17'($signed(edg_s1[v].b)) - 17'($signed(edg_s1[v].a));
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			vtx_d[v].pa  = edg_s1[v].pa;
			vtx_d[v].pb  = edg_s1[v].pb;
			vtx_d[v].rem = {1'b0, num[15:0]};
			vtx_d[v].den = den[15:0];
			vtx_d[v].q   = '0;
			vtx_d[v].frc = (den == 0) || (num <= 0) || (num >= den);
			vtx_d[v].one = (den != 0) && (num > 0) && (num >= den);
		end
	end

	function automatic vtx_t div_step(input vtx_t x);
		vtx_t        r;
		logic [16:0] r2;
		logic        ge;
		r  = x;
		r2 = {x.rem[15:0], 1'b0};
		ge = r2 >= {1'b0, x.den};
		r.rem = ge ? (r2 - {1'b0, x.den}) : r2;
		r.q   = {x.q[F-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			for (int i = 0; i < F; i++) begin
				ctl_s3[i] <= '0;
			end
		end else if (adv) begin
			ctl_s1.valid <= busy_q && mask_q[slot_q];
			ctl_s1.tet   <= slot_q[3:1];
			ctl_s1.last  <= slot_q == last_q;
			ctl_s2       <= ctl_s1;
			ctl_s3[0]    <= ctl_s2;
			for (int i = 1; i < F; i++) begin
				ctl_s3[i] <= ctl_s3[i-1];
			end
			ctl_s4 <= ctl_s3[F-1];
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			edg_s1 <= edg_d;
			vtx_s2 <= vtx_d;
			for (int v = 0; v < 3; v++) begin
				vtx_s3[0][v] <= div_step(vtx_s2[v]);
				for (int i = 1; i < F; i++) begin
					vtx_s3[i][v] <= div_step(vtx_s3[i-1][v]);
				end
			end
		end
	end

	// interpolation multiply and rounding
	always_ff @(posedge clk) begin
		logic [F:0]         u;
		logic signed [16:0] diff;
		logic signed [PW-1:0] rnd;
		if (adv) begin
			for (int v = 0; v < 3; v++) begin
				if (vtx_s3[F-1][v].frc) begin
					u = vtx_s3[F-1][v].one ? {1'b1, {F{1'b0}}} : '0;
				end else begin
					u = {1'b0, vtx_s3[F-1][v].q};
				end
				for (int d = 0; d < 3; d++) begin
					diff = 17'($signed(vtx_s3[F-1][v].pb[d]))
					     - 17'($signed(vtx_s3[F-1][v].pa[d]));
					prod_s4[v][d] <= PW'(diff * $signed({1'b0, u}));
					pa_s4[v][d]   <= vtx_s3[F-1][v].pa[d];
				end
			end
			for (int v = 0; v < 3; v++) begin
				for (int d = 0; d < 3; d++) begin
					rnd = $signed(prod_s4[v][d]) + $signed(PW'(1) << (F - 1));
					p_s5[v][d] <= pa_s4[v][d] + 16'(rnd >>> F);
				end
			end
		end
	end

	assign triangle_valid        = ctl_s5.valid;
	assign triangle.p0_x         = p_s5[0][0];
	assign triangle.p0_y         = p_s5[0][1];
	assign triangle.p0_z         = p_s5[0][2];
	assign triangle.p1_x         = p_s5[1][0];
	assign triangle.p1_y         = p_s5[1][1];
	assign triangle.p1_z         = p_s5[1][2];
	assign triangle.p2_x         = p_s5[2][0];
	assign triangle.p2_y         = p_s5[2][1];
	assign triangle.p2_z         = p_s5[2][2];
	assign triangle.tet_number   = ctl_s5.tet;
	assign triangle.last_of_cell = ctl_s5.last;

endmodule

`default_nettype wire

// ===== verif/hex_marching_tetrahedra_tb.sv =====
// ----------------------------------------------------------------------------
// hex_marching_tetrahedra_tb
// drives hex cells through the tetrahedra splitter under random idling and
// back pressure, predicts every triangle in order and checks it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module hex_marching_tetrahedra_tb
	import hmt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int N_RANDOM = 350;
	localparam int SETTLE = 64;

	class surface_board;
		tri_t        pending[$];
		logic signed [15:0] iso;
		int          errors;
		int          tris_seen;
		int          cells_seen;

		function new();
			iso = 0;
			errors = 0;
			tris_seen = 0;
			cells_seen = 0;
		endfunction

		function automatic logic [2:0] corner_of(int t, int c);
			logic [2:0] m[6][4];
			m = '{'{0, 5, 4, 6}, '{0, 7, 5, 6}, '{0, 2, 7, 6},
				'{0, 7, 1, 5}, '{0, 1, 7, 2}, '{3, 7, 1, 2}};
			return m[t][c];
		endfunction

		function automatic int unsigned frac(int a, int b);
			int num;
			int den;
			longint unsigned q;
			num = iso - a;
			den = b - a;
			if (den == 0) return 0;
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num <= 0) return 0;
			if (num >= den) return 1 << FRAC;
			q = (longint'(num) << FRAC) / den;
			return q;
		endfunction

		function automatic logic [15:0] lerp(int pa, int pb, int unsigned u);
			longint prod;
			prod = longint'(pb - pa) * longint'(u) + (longint'(1) << (FRAC - 1));
			return pa + int'(prod >>> FRAC);
		endfunction

		function void note_cell(hex_t h);
			logic [63:0] cr[8];
			int pos[8][3];
			int val[8];
			int e[4][3][2];
			int ne;
			int code;
			int ca;
			int cb;
			int lo;
			int hi;
			int unsigned u;
			logic [15:0] pt[3][3];
			tri_t r;
			int first;
			cr = '{h.corner_0, h.corner_1, h.corner_2, h.corner_3,
				h.corner_4, h.corner_5, h.corner_6, h.corner_7};
			first = pending.size();
			for (int c = 0; c < 8; c++) begin
				for (int d = 0; d < 3; d++) pos[c][d] = $signed(cr[c][16*d +: 16]);
				val[c] = $signed(cr[c][63:48]);
			end
			for (int t = 0; t < 6; t++) begin
				code = 0;
				for (int c = 0; c < 4; c++)
					if (val[corner_of(t, c)] < iso) code |= 1 << c;
				ne = 0;
				case (code)
					1, 14: begin e[0] = '{'{0,1},'{0,2},'{0,3}}; ne = 1; end
					2, 13: begin e[0] = '{'{1,0},'{1,3},'{1,2}}; ne = 1; end
					4, 11: begin e[0] = '{'{2,0},'{2,1},'{2,3}}; ne = 1; end
					7, 8:  begin e[0] = '{'{3,0},'{3,2},'{3,1}}; ne = 1; end
					3, 12: begin
						e[0] = '{'{0,3},'{0,2},'{1,3}};
						e[1] = '{'{1,3},'{1,2},'{0,2}}; ne = 2;
					end
					5, 10: begin
						e[0] = '{'{0,1},'{2,3},'{0,3}};
						e[1] = '{'{0,1},'{1,2},'{2,3}}; ne = 2;
					end
					6, 9: begin
						e[0] = '{'{0,1},'{1,3},'{2,3}};
						e[1] = '{'{0,1},'{0,2},'{2,3}}; ne = 2;
					end
					default: ne = 0;
				endcase
				for (int k = 0; k < ne; k++) begin
					for (int v = 0; v < 3; v++) begin
						ca = corner_of(t, e[k][v][0]);
						cb = corner_of(t, e[k][v][1]);
						lo = ca < cb ? ca : cb;
						hi = ca < cb ? cb : ca;
						u = frac(val[lo], val[hi]);
						for (int d = 0; d < 3; d++)
							pt[v][d] = lerp(pos[lo][d], pos[hi][d], u);
					end
					r = '{pt[0][0], pt[0][1], pt[0][2], pt[1][0], pt[1][1], pt[1][2],
						pt[2][0], pt[2][1], pt[2][2], 3'(t), 1'b0};
					pending.push_back(r);
				end
			end
			if (pending.size() > first) pending[$].last_of_cell = 1'b1;
			cells_seen++;
		endfunction

		function void check_triangle(tri_t got);
			tri_t w;
			tris_seen++;
			if (pending.size() == 0) begin
				report("unexpected triangle", 0, got);
				return;
			end
			w = pending.pop_front();
			if (got.p0_x !== w.p0_x) report("p0_x", w.p0_x, got.p0_x);
			if (got.p0_y !== w.p0_y) report("p0_y", w.p0_y, got.p0_y);
			if (got.p0_z !== w.p0_z) report("p0_z", w.p0_z, got.p0_z);
			if (got.p1_x !== w.p1_x) report("p1_x", w.p1_x, got.p1_x);
			if (got.p1_y !== w.p1_y) report("p1_y", w.p1_y, got.p1_y);
			if (got.p1_z !== w.p1_z) report("p1_z", w.p1_z, got.p1_z);
			if (got.p2_x !== w.p2_x) report("p2_x", w.p2_x, got.p2_x);
			if (got.p2_y !== w.p2_y) report("p2_y", w.p2_y, got.p2_y);
			if (got.p2_z !== w.p2_z) report("p2_z", w.p2_z, got.p2_z);
			if (got.tet_number !== w.tet_number)
				report("tet_number", w.tet_number, got.tet_number);
			if (got.last_of_cell !== w.last_of_cell)
				report("last_of_cell", w.last_of_cell, got.last_of_cell);
		endfunction

		function void report(string what, logic [159:0] exp_v, logic [159:0] got_v);
			errors++;
			if (errors <= 40)
				$display("mismatch %0s at triangle %0d: expected %0h got %0h",
					what, tris_seen, exp_v, got_v);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        hex_valid = 1'b0;
	wire         hex_stall;
	hex_t        hex = '0;
	wire         triangle_valid;
	logic        triangle_stall = 1'b0;
	tri_t        triangle;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic [15:0] cfg_data = '0;

	surface_board sb = new();
	bit draining = 1'b0;

	hex_marching_tetrahedra #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.hex_valid(hex_valid), .hex_stall(hex_stall), .hex(hex),
		.triangle_valid(triangle_valid), .triangle_stall(triangle_stall),
		.triangle(triangle),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] make_corner(logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic [15:0] v);
		return {v, z, y, x};
	endfunction

	function automatic logic [15:0] rand_value(logic signed [15:0] lvl);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 16'(int'(lvl) + $urandom_range(0, 400) - 200);
		if (r < 6) return lvl;
		if (r < 7) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		return 16'($urandom);
	endfunction

	function automatic hex_t rand_cell(logic signed [15:0] lvl, int mode);
		hex_t h;
		logic [63:0] c[8];
		logic [15:0] same_v;
		same_v = rand_value(lvl);
		for (int i = 0; i < 8; i++) begin
			if (mode == 0)
				c[i] = {16'($urandom), 16'($urandom), 16'($urandom), rand_value(lvl)}
					& 64'hffffffffffffffff;
			else
				c[i] = make_corner(16'($urandom_range(0, 200) - 100),
					16'($urandom_range(0, 200) - 100),
					16'($urandom_range(0, 200) - 100),
					(mode == 2 && i[0]) ? same_v : rand_value(lvl));
			if (mode == 0) c[i] = {rand_value(lvl), c[i][47:0]};
		end
		h = '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
		return h;
	endfunction

	task automatic send_cell(hex_t h);
		int g;
		g = gap_len();
		if (g > 0) begin
			hex_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		hex_valid <= 1'b1;
		hex <= h;
		do @(posedge clk); while (hex_stall);
		sb.note_cell(h);
	endtask

	task automatic wait_drained();
		hex_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_iso(logic [15:0] lvl);
		cfg_valid <= 1'b1;
		cfg_data <= lvl;
		do @(posedge clk); while (!cfg_ready);
		sb.iso = lvl;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && triangle_valid && !triangle_stall) sb.check_triangle(triangle);
		if (draining) triangle_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 8) triangle_stall <= 1'b1;
		else if ($urandom_range(0, 99) < 40) triangle_stall <= 1'b0;
	end

	initial begin
		logic [15:0] levels[5];
		logic [63:0] c;
		levels = '{16'h0000, 16'h8000, 16'h7fff, 16'hff38, 16'h0064};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		// directed: extremes, equal values, uniform cells, each single-corner case
		send_cell('0);
		send_cell('1);
		c = make_corner(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_cell('{c, c, c, c, make_corner(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff),
			c, c, c});
		for (int k = 0; k < 8; k++) begin
			logic [63:0] cs[8];
			for (int i = 0; i < 8; i++)
				cs[i] = make_corner(16'(i * 1000), 16'(-i * 700), 16'(i * 333),
					(i == k) ? 16'hfff0 : 16'h0040);
			send_cell('{cs[0], cs[1], cs[2], cs[3], cs[4], cs[5], cs[6], cs[7]});
		end
		for (int k = 0; k < 9; k++) send_cell(rand_cell(0, k % 3));
		wait_drained();
		for (int p = 0; p < 5; p++) begin
			write_iso(levels[p]);
			for (int n = 0; n < N_RANDOM / 5; n++)
				send_cell(rand_cell(sb.iso, ($urandom_range(0, 9) < 2) ? 0
					: $urandom_range(1, 2)));
			wait_drained();
		end
		draining = 1'b1;
		wait_drained();
		$display("covered %0d cells and %0d triangles over five iso levels",
			sb.cells_seen, sb.tris_seen);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
